// ----- design/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types, codes and helper functions of the sparse radix array engine.
// ----------------------------------------------------------------------------
package sra_pkg;

   localparam int CMD_W          = 2;
   localparam int INDEX_W        = 20;
   localparam int VALUE_W        = 32;
   localparam int STATUS_W       = 2;
   localparam int COUNT_W        = 21;
   localparam int NIB_W          = 4;
   localparam int LEVEL_W        = 3;
   localparam int SLOTS_PER_NODE = 16;
   localparam int MAX_LEVELS     = 5;

   localparam int DEFAULT_NODE_COUNT = 256;
   localparam int DEFAULT_VALUE_BITS = 32;

   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_NODES = 2'd3;

   // Classified operation handed from the front part to the back part.
   // A probe walks the tree only to report the slot, with a rejected status.
   typedef enum logic [2:0] {
      OP_GET    = 3'd0,
      OP_SET    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_PROBE  = 3'd3,
      OP_NOFIT  = 3'd4
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [LEVEL_W-1:0]   levels;
      logic [INDEX_W-1:0]   index;
      logic [VALUE_W-1:0]   value;
   } item_type;

   // Number of tree levels above the leaves that an index needs.
   function automatic logic [LEVEL_W-1:0] levels_of(input logic [INDEX_W-1:0] idx);
      logic [LEVEL_W-1:0] d;
      if (idx[19:16] != 4'd0) begin
         d = 3'd4;
      end else if (idx[15:12] != 4'd0) begin
         d = 3'd3;
      end else if (idx[11:8] != 4'd0) begin
         d = 3'd2;
      end else if (idx[7:4] != 4'd0) begin
         d = 3'd1;
      end else begin
         d = 3'd0;
      end
      return d;
   endfunction

   // Slot number used by an index at a given level.
   function automatic logic [NIB_W-1:0] nibble_at(input logic [INDEX_W-1:0] idx,
                                                  input logic [LEVEL_W-1:0] lvl);
      logic [NIB_W-1:0] n;
      case (lvl)
         3'd0: n = idx[3:0];
         3'd1: n = idx[7:4];
         3'd2: n = idx[11:8];
         3'd3: n = idx[15:12];
         3'd4: n = idx[19:16];
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- design/sra_channels.sv -----
// ----------------------------------------------------------------------------
// sra_channels
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface sra_req_if;
   logic                          valid;
   logic                          ready;
   logic [sra_pkg::CMD_W-1:0]     cmd;
   logic [sra_pkg::INDEX_W-1:0]   index;
   logic [sra_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output cmd, output index, output value, input ready);
   modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface sra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sra_pkg::STATUS_W-1:0]  status;
   logic [sra_pkg::VALUE_W-1:0]   read_value;
   logic [sra_pkg::COUNT_W-1:0]   value_count;
   logic signed [sra_pkg::COUNT_W-1:0] highest_index;
   logic                          has_gaps;

   modport source (output valid, output status, output read_value, output value_count,
                   output highest_index, output has_gaps, input ready);
   modport sink   (input valid, input status, input read_value, input value_count,
                   input highest_index, input has_gaps, output ready);
endinterface

// ----- design/sra_front.sv -----
// ----------------------------------------------------------------------------
// sra_front
// Accepts request transactions, classifies them and holds them in a
// two-entry queue for the tree walker.
// ----------------------------------------------------------------------------
module sra_front #(
   parameter int VALUE_BITS = sra_pkg::DEFAULT_VALUE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   sra_req_if.sink            req,
   output logic               q_valid,
   output sra_pkg::item_type  q_item,
   input  logic               q_take
);

   sra_pkg::item_type q_mem_ff [2];
   logic              head_ff, head_in;
   logic              tail_ff, tail_in;
   logic [1:0]        cnt_ff, cnt_in;

   sra_pkg::item_type     cls;
   logic [VALUE_BITS-1:0] masked;
   logic                  push;

   always_comb begin
      masked     = VALUE_BITS'(req.value);
      cls.index  = req.index;
      cls.value  = req.value;
      cls.levels = sra_pkg::levels_of(req.index);
      if (cls.levels >= sra_pkg::LEVEL_W'(sra_pkg::MAX_LEVELS)) begin
         cls.op = sra_pkg::OP_NOFIT;
      end else begin
         case (req.cmd)
            sra_pkg::CMD_GET:    cls.op = sra_pkg::OP_GET;
            sra_pkg::CMD_SET:    cls.op = (masked == '0) ? sra_pkg::OP_PROBE : sra_pkg::OP_SET;
            sra_pkg::CMD_REMOVE: cls.op = sra_pkg::OP_REMOVE;
            default:             cls.op = sra_pkg::OP_PROBE;
         endcase
      end
   end

   assign req.ready = enable && (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_mem_ff[head_ff];

   always_comb begin
      head_in = q_take ? ~head_ff : head_ff;
      tail_in = push ? ~tail_ff : tail_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         tail_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[tail_ff] <= cls;
      end
   end

endmodule

// ----- design/sra_back.sv -----
// ----------------------------------------------------------------------------
// sra_back
// Tree walker: owns the node store, walks one level per cycle, grows the
// tree and takes nodes from the pool, and registers the response.
// ----------------------------------------------------------------------------
module sra_back #(
   parameter int NODE_COUNT = sra_pkg::DEFAULT_NODE_COUNT,
   parameter int VALUE_BITS = sra_pkg::DEFAULT_VALUE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   output logic               ready_for_items,
   input  logic               q_valid,
   input  sra_pkg::item_type  q_item,
   output logic               q_take,
   sra_rsp_if.source          rsp
);

   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int ADDR_W     = NODE_W + sra_pkg::NIB_W;
   localparam int STORE_SIZE = NODE_COUNT * sra_pkg::SLOTS_PER_NODE;
   localparam int FREE_W     = $clog2(NODE_COUNT + 1);
   localparam int CMP_W      = (FREE_W > 4) ? FREE_W : 4;
   localparam int WIDE_W     = VALUE_BITS + 17;
   localparam int LW         = sra_pkg::LEVEL_W;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_DEEPEN = 5'b01000,
      ST_ALLOC  = 5'b10000
   } state_type;

   logic [VALUE_BITS-1:0] store [STORE_SIZE];
   logic [VALUE_BITS-1:0] rd_q_ff;

   state_type                   state_ff, state_in;
   sra_pkg::item_type           cur_ff, cur_in;
   logic [NODE_W-1:0]           node_ff, node_in;
   logic [LW-1:0]               lv_ff, lv_in;
   logic [FREE_W-1:0]           free_ff, free_in;
   logic [NODE_W-1:0]           root_ff, root_in;
   logic [LW-1:0]               depth_ff, depth_in;
   logic [sra_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sra_pkg::COUNT_W-1:0] top_ff, top_in;
   logic                        gap_ff, gap_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sra_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [sra_pkg::VALUE_W-1:0] read_ff, read_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [VALUE_BITS-1:0]       wr_data;
   logic [ADDR_W-1:0]           rd_addr;

   logic                        fin;
   logic [sra_pkg::STATUS_W-1:0] fin_status;
   logic [sra_pkg::VALUE_W-1:0] fin_read;
   logic                        set_done;
   logic [VALUE_BITS-1:0]       val_v;
   logic [NODE_W-1:0]           child;
   logic [NODE_W-1:0]           free_node;
   logic                        missing;
   logic [CMP_W-1:0]            avail;
   logic [3:0]                  need_deep;
   logic signed [21:0]          idx_s, top_s;

   always_comb begin
      val_v     = VALUE_BITS'(cur_ff.value);
      child     = NODE_W'(rd_q_ff - VALUE_BITS'(1));
      free_node = NODE_W'(free_ff);
      missing   = (rd_q_ff == '0) || ({17'd0, rd_q_ff} > WIDE_W'(NODE_COUNT));
      avail     = CMP_W'(FREE_W'(NODE_COUNT) - free_ff);
      need_deep = 4'(q_item.levels - depth_ff) + 4'(q_item.levels);
      idx_s     = $signed({2'b00, cur_ff.index});
      top_s     = $signed({top_ff[sra_pkg::COUNT_W-1], top_ff});
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      node_in      = node_ff;
      lv_in        = lv_ff;
      free_in      = free_ff;
      root_in      = root_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      gap_in       = gap_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      read_in      = read_ff;
      wr_en        = 1'b0;
      wr_addr      = {node_ff, sra_pkg::nibble_at(cur_ff.index, lv_ff)};
      wr_data      = '0;
      rd_addr      = {root_ff, sra_pkg::nibble_at(q_item.index, depth_ff)};
      q_take       = 1'b0;
      fin          = 1'b0;
      fin_status   = sra_pkg::STATUS_DONE;
      fin_read     = '0;
      set_done     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(STORE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp.ready)) begin
               q_take = 1'b1;
               cur_in = q_item;
               if (q_item.op == sra_pkg::OP_NOFIT) begin
                  fin        = 1'b1;
                  fin_status = sra_pkg::STATUS_REJECTED;
               end else if (q_item.levels > depth_ff) begin
                  if (q_item.op == sra_pkg::OP_SET) begin
                     if (CMP_W'(need_deep) > avail) begin
                        fin        = 1'b1;
                        fin_status = sra_pkg::STATUS_NO_NODES;
                     end else begin
                        state_in = ST_DEEPEN;
                     end
                  end else begin
                     fin        = 1'b1;
                     fin_status = (q_item.op == sra_pkg::OP_PROBE) ?
                                  sra_pkg::STATUS_REJECTED : sra_pkg::STATUS_EMPTY;
                  end
               end else begin
                  node_in  = root_ff;
                  lv_in    = depth_ff;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (lv_ff == '0) begin
               fin = 1'b1;
               case (cur_ff.op)
                  sra_pkg::OP_SET: begin
                     wr_en    = 1'b1;
                     wr_data  = val_v;
                     set_done = 1'b1;
                     if (rd_q_ff == '0) begin
                        count_in = count_ff + sra_pkg::COUNT_W'(1);
                     end
                     fin_read = sra_pkg::VALUE_W'(val_v);
                  end
                  sra_pkg::OP_REMOVE: begin
                     if (rd_q_ff != '0) begin
                        wr_en    = 1'b1;
                        count_in = count_ff - sra_pkg::COUNT_W'(1);
                     end else begin
                        fin_status = sra_pkg::STATUS_EMPTY;
                     end
                  end
                  sra_pkg::OP_GET: begin
                     fin_read   = sra_pkg::VALUE_W'(rd_q_ff);
                     fin_status = (rd_q_ff == '0) ? sra_pkg::STATUS_EMPTY :
                                  sra_pkg::STATUS_DONE;
                  end
                  default: begin
                     fin_read   = sra_pkg::VALUE_W'(rd_q_ff);
                     fin_status = sra_pkg::STATUS_REJECTED;
                  end
               endcase
            end else if (missing) begin
               if (cur_ff.op == sra_pkg::OP_SET) begin
                  if (CMP_W'(lv_ff) > avail) begin
                     fin        = 1'b1;
                     fin_status = sra_pkg::STATUS_NO_NODES;
                  end else begin
                     state_in = ST_ALLOC;
                  end
               end else begin
                  fin        = 1'b1;
                  fin_status = (cur_ff.op == sra_pkg::OP_PROBE) ?
                               sra_pkg::STATUS_REJECTED : sra_pkg::STATUS_EMPTY;
               end
            end else begin
               node_in = child;
               lv_in   = lv_ff - LW'(1);
               rd_addr = {child, sra_pkg::nibble_at(cur_ff.index, lv_ff - LW'(1))};
            end
         end
         ST_DEEPEN: begin
            // The new root keeps the old tree under its first slot.
            wr_en    = 1'b1;
            wr_addr  = {free_node, sra_pkg::NIB_W'(0)};
            wr_data  = VALUE_BITS'(root_ff) + VALUE_BITS'(1);
            root_in  = free_node;
            free_in  = free_ff + FREE_W'(1);
            depth_in = depth_ff + LW'(1);
            if (depth_ff + LW'(1) == cur_ff.levels) begin
               node_in  = free_node;
               lv_in    = cur_ff.levels;
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            wr_en = 1'b1;
            if (lv_ff != '0) begin
               wr_data = VALUE_BITS'(free_ff) + VALUE_BITS'(1);
               node_in = free_node;
               free_in = free_ff + FREE_W'(1);
               lv_in   = lv_ff - LW'(1);
            end else begin
               wr_data  = val_v;
               count_in = count_ff + sra_pkg::COUNT_W'(1);
               set_done = 1'b1;
               fin      = 1'b1;
               fin_read = sra_pkg::VALUE_W'(val_v);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (set_done) begin
         if (idx_s > top_s + 22'sd1) begin
            gap_in = 1'b1;
         end
         if (idx_s > top_s) begin
            top_in = idx_s[sra_pkg::COUNT_W-1:0];
         end
      end

      if (fin) begin
         rsp_valid_in = 1'b1;
         status_in    = fin_status;
         read_in      = fin_read;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_ff      <= FREE_W'(1);
         root_ff      <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         top_ff       <= '1;
         gap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         root_ff      <= root_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      node_ff   <= node_in;
      lv_ff     <= lv_in;
      status_ff <= status_in;
      read_ff   <= read_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_q_ff <= store[rd_addr];
   end

   assign ready_for_items   = (state_ff != ST_CLEAR);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.read_value    = read_ff;
   assign rsp.value_count   = count_ff;
   assign rsp.highest_index = $signed(top_ff);
   assign rsp.has_gaps      = gap_ff;

endmodule

// ----- design/sparse_radix_array_engine_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_radix_array_engine_unit
// Sparse array kept as a 16-way radix tree of up to five levels in a node pool.
// ----------------------------------------------------------------------------
// Each request transaction is a get, set or remove at a 20-bit index, and each
// one yields exactly one response transaction carrying the status, the slot
// contents after the access, the occupied count, the highest index ever set
// and the gaps flag. After reset all 16 * NODE_COUNT entries of the node store
// (4096 with the default pool) are swept to zero, one entry per cycle; requests
// are held off until the sweep ends. The node store has one read and one write
// port, so the walker handles one transaction at a time: an item that is
// rejected outright or is a get or remove above the current tree is answered
// without a walk, and a walk takes the item and then visits each level of the
// tree in turn, leaf level included. A set that has to take new nodes first
// adds a new root per missing level when the tree grows, then writes a pointer
// for each missing node on its path and finally the leaf. Up to two classified
// transactions wait in a queue ahead of the walker, and the response register
// lets the walker start the next item in the same cycle its previous response
// is taken.
// ----------------------------------------------------------------------------
module sparse_radix_array_engine_unit #(
   parameter int NODE_COUNT = sra_pkg::DEFAULT_NODE_COUNT,
   parameter int VALUE_BITS = sra_pkg::DEFAULT_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   sra_req_if.sink     req_chan,
   sra_rsp_if.source   rsp_chan
);

   // Queue handshake between the classifier and the walker.
   logic              q_valid;
   logic              q_take;
   sra_pkg::item_type q_item;
   logic              walker_ready;

   // The front classifies each transaction (index out of range, set of zero,
   // unused command) so the walker only sees a small set of operations.
   sra_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .enable  (walker_ready),
      .req     (req_chan),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_take  (q_take)
   );

   // The back walks the tree, grows it when a set needs it and drives the
   // response channel.
   sra_back #(
      .NODE_COUNT (NODE_COUNT),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ready_for_items (walker_ready),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_take          (q_take),
      .rsp             (rsp_chan)
   );

   // The walker never starts an item while an untaken response is pending.
   assert property (@(posedge clock) disable iff (reset)
      q_take |-> (q_valid && (!rsp_chan.valid || rsp_chan.ready)))
      else $error("walker took an item while the response register was full");

   // Once a gap has been seen the flag stays set.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_chan.has_gaps)) |-> rsp_chan.has_gaps)
      else $error("gaps flag cleared");

   // The highest index ever set never moves down.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_chan.highest_index >= $past(rsp_chan.highest_index)))
      else $error("highest index decreased");

endmodule

// ----- sim/sra_tb_channels.sv -----
// ----------------------------------------------------------------------------
// sra_tb_channels
// Note: the request and response channel interfaces are taken from the design
// file sra_channels.sv; this file only holds the small types that the
// testbench shares between its processes.
// ----------------------------------------------------------------------------
package sra_tb_pkg;

   typedef struct {
      logic [sra_pkg::STATUS_W-1:0]       status;
      logic [sra_pkg::VALUE_W-1:0]        read_value;
      logic [sra_pkg::COUNT_W-1:0]        value_count;
      logic signed [sra_pkg::COUNT_W-1:0] highest_index;
      logic                               has_gaps;
   } reply_type;

endpackage

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sparse radix array engine.
// ----------------------------------------------------------------------------
// A directed table covers the corners of the index space, every command and the
// rejected cases; then random gets, sets and removes are sent, most of them
// clustered on a few regions so that reads find the values written before.
// Every response transaction is checked against a shadow radix tree kept
// inside the bench.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_NODES = sra_pkg::DEFAULT_NODE_COUNT;
   localparam logic [sra_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic clock;
   logic reset;

   sra_req_if req_chan ();
   sra_rsp_if rsp_chan ();

   sparse_radix_array_engine_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow of the tree: same node layout as the block keeps.
   logic [sra_pkg::VALUE_W-1:0] shadow_store [POOL_NODES*sra_pkg::SLOTS_PER_NODE];
   int unsigned                 shadow_root;
   int unsigned                 shadow_depth;
   int unsigned                 shadow_next_free;
   int unsigned                 shadow_count;
   int                          shadow_top;
   bit                          shadow_gaps;

   sra_tb_pkg::reply_type       pending_replies [$];
   int                          mismatch_count;
   bit                          quiet_stretch;

   function automatic int unsigned depth_for(input logic [sra_pkg::INDEX_W-1:0] idx);
      int unsigned d;
      d = 0;
      while (d < 4 && idx >= (20'd1 << (4 * (d + 1)))) d++;
      return d;
   endfunction

   function automatic int unsigned nib(input logic [sra_pkg::INDEX_W-1:0] idx,
                                       input int unsigned lvl);
      return (idx >> (4 * lvl)) & 15;
   endfunction

   // Leaf slot position for idx, or -1 when the path is missing.
   function automatic int leaf_position(input logic [sra_pkg::INDEX_W-1:0] idx);
      int unsigned node;
      int unsigned c;
      if (depth_for(idx) > shadow_depth) return -1;
      node = shadow_root;
      for (int l = shadow_depth; l > 0; l--) begin
         c = shadow_store[node * sra_pkg::SLOTS_PER_NODE + nib(idx, l)];
         if (c == 0 || c > POOL_NODES) return -1;
         node = c - 1;
      end
      return node * sra_pkg::SLOTS_PER_NODE + nib(idx, 0);
   endfunction

   function automatic int unsigned nodes_to_take(input logic [sra_pkg::INDEX_W-1:0] idx);
      int unsigned d;
      int unsigned node;
      int unsigned c;
      d = depth_for(idx);
      if (d > shadow_depth) return (d - shadow_depth) + d;
      node = shadow_root;
      for (int l = shadow_depth; l > 0; l--) begin
         c = shadow_store[node * sra_pkg::SLOTS_PER_NODE + nib(idx, l)];
         if (c == 0 || c > POOL_NODES) return l;
         node = c - 1;
      end
      return 0;
   endfunction

   function automatic logic [sra_pkg::STATUS_W-1:0] store_value(
         input logic [sra_pkg::INDEX_W-1:0] idx,
         input logic [sra_pkg::VALUE_W-1:0] val);
      int unsigned d;
      int unsigned node;
      int unsigned pos;
      d = depth_for(idx);
      if (nodes_to_take(idx) > POOL_NODES - shadow_next_free) return sra_pkg::STATUS_NO_NODES;
      while (shadow_depth < d) begin
         shadow_store[shadow_next_free * sra_pkg::SLOTS_PER_NODE] = shadow_root + 1;
         shadow_root = shadow_next_free;
         shadow_next_free++;
         shadow_depth++;
      end
      node = shadow_root;
      for (int l = shadow_depth; l > 0; l--) begin
         pos = node * sra_pkg::SLOTS_PER_NODE + nib(idx, l);
         if (shadow_store[pos] == 0) begin
            shadow_store[pos] = shadow_next_free + 1;
            shadow_next_free++;
         end
         node = shadow_store[pos] - 1;
      end
      pos = node * sra_pkg::SLOTS_PER_NODE + nib(idx, 0);
      if (shadow_store[pos] == 0) shadow_count++;
      shadow_store[pos] = val;
      if (int'(idx) > shadow_top + 1) shadow_gaps = 1;
      if (int'(idx) > shadow_top) shadow_top = int'(idx);
      return sra_pkg::STATUS_DONE;
   endfunction

   // Applies one request to the shadow tree and returns the response it causes.
   function automatic sra_tb_pkg::reply_type apply_access(
         input logic [sra_pkg::CMD_W-1:0]   cmd,
         input logic [sra_pkg::INDEX_W-1:0] idx,
         input logic [sra_pkg::VALUE_W-1:0] val);
      sra_tb_pkg::reply_type r;
      bit fits;
      int pos;
      fits = depth_for(idx) < sra_pkg::MAX_LEVELS;
      if (!fits || cmd == CMD_UNUSED) begin
         r.status = sra_pkg::STATUS_REJECTED;
      end else if (cmd == sra_pkg::CMD_SET) begin
         r.status = (val == 0) ? sra_pkg::STATUS_REJECTED : store_value(idx, val);
      end else begin
         pos = leaf_position(idx);
         if (pos < 0 || shadow_store[pos] == 0) begin
            r.status = sra_pkg::STATUS_EMPTY;
         end else begin
            r.status = sra_pkg::STATUS_DONE;
            if (cmd == sra_pkg::CMD_REMOVE) begin
               shadow_store[pos] = 0;
               shadow_count--;
            end
         end
      end
      pos = fits ? leaf_position(idx) : -1;
      r.read_value    = (pos < 0) ? '0 : shadow_store[pos];
      r.value_count   = sra_pkg::COUNT_W'(shadow_count);
      r.highest_index = sra_pkg::COUNT_W'(shadow_top);
      r.has_gaps      = shadow_gaps;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("sparse_radix_array_engine_unit verification failed");
      $finish;
   end

   // Sends one request transaction; the expectation is queued at acceptance.
   // A directed row may carry a typed status that must agree with the shadow.
   task automatic send_access(input logic [sra_pkg::CMD_W-1:0] cmd,
                              input logic [sra_pkg::INDEX_W-1:0] idx,
                              input logic [sra_pkg::VALUE_W-1:0] val,
                              input int typed_status);
      sra_tb_pkg::reply_type r;
      while (!quiet_stretch && $urandom_range(99) < 10) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.index <= idx;
      req_chan.value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      r = apply_access(cmd, idx, val);
      if (typed_status >= 0 && r.status != typed_status) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("directed row cmd %0d index %h: table status %0d, shadow %0d",
                     cmd, idx, typed_status, r.status);
      end
      pending_replies.push_back(r);
   endtask

   // Response side: random stalls, field by field compare.
   always @(posedge clock) begin
      sra_tb_pkg::reply_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response transaction");
         end else begin
            e = pending_replies.pop_front();
            if (rsp_chan.status !== e.status || rsp_chan.read_value !== e.read_value ||
                rsp_chan.value_count !== e.value_count ||
                rsp_chan.highest_index !== e.highest_index ||
                rsp_chan.has_gaps !== e.has_gaps) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected st %0d val %h cnt %0d top %0d gap %0d,",
                            " got st %0d val %h cnt %0d top %0d gap %0d"},
                           e.status, e.read_value, e.value_count, e.highest_index,
                           e.has_gaps, rsp_chan.status, rsp_chan.read_value,
                           rsp_chan.value_count, rsp_chan.highest_index,
                           rsp_chan.has_gaps);
            end
         end
      end
      rsp_chan.ready <= reset || quiet_stretch || ($urandom_range(99) >= 10);
   end

   typedef struct {
      logic [sra_pkg::CMD_W-1:0]   cmd;
      logic [sra_pkg::INDEX_W-1:0] idx;
      logic [sra_pkg::VALUE_W-1:0] val;
      int                          status;
   } access_row_type;

   // Directed table; -1 in the status column means only the shadow decides.
   access_row_type access_table [] = '{
      '{sra_pkg::CMD_GET,    20'h00000, 32'h0,        sra_pkg::STATUS_EMPTY},
      '{sra_pkg::CMD_REMOVE, 20'h00005, 32'h0,        sra_pkg::STATUS_EMPTY},
      '{sra_pkg::CMD_SET,    20'h00000, 32'h0,        sra_pkg::STATUS_REJECTED},
      '{sra_pkg::CMD_SET,    20'h00000, 32'hFFFFFFFF, sra_pkg::STATUS_DONE},
      '{sra_pkg::CMD_GET,    20'h00000, 32'h0,        sra_pkg::STATUS_DONE},
      '{sra_pkg::CMD_SET,    20'h00001, 32'h00000001, sra_pkg::STATUS_DONE},
      '{sra_pkg::CMD_SET,    20'h00003, 32'h5A5A5A5A, -1},
      '{sra_pkg::CMD_SET,    20'h00003, 32'hA5A5A5A5, -1},
      '{sra_pkg::CMD_SET,    20'h00010, 32'h12345678, -1},
      '{sra_pkg::CMD_SET,    20'hFFFFF, 32'hDEADBEEF, -1},
      '{sra_pkg::CMD_GET,    20'hFFFFF, 32'h0,        sra_pkg::STATUS_DONE},
      '{sra_pkg::CMD_GET,    20'hFFFFE, 32'h0,        sra_pkg::STATUS_EMPTY},
      '{sra_pkg::CMD_GET,    20'h10000, 32'h0,        sra_pkg::STATUS_EMPTY},
      '{sra_pkg::CMD_REMOVE, 20'h00003, 32'h0,        sra_pkg::STATUS_DONE},
      '{sra_pkg::CMD_REMOVE, 20'h00003, 32'h0,        sra_pkg::STATUS_EMPTY},
      '{CMD_UNUSED,          20'h00001, 32'hFFFFFFFF, sra_pkg::STATUS_REJECTED},
      '{sra_pkg::CMD_SET,    20'h0F0F0, 32'h0000FFFF, -1},
      '{sra_pkg::CMD_SET,    20'h80000, 32'h80000000, -1},
      '{sra_pkg::CMD_GET,    20'h00001, 32'h0,        sra_pkg::STATUS_DONE}
   };

   initial begin
      logic [sra_pkg::CMD_W-1:0]   cmd;
      logic [sra_pkg::INDEX_W-1:0] idx;
      logic [sra_pkg::INDEX_W-1:0] region;
      logic [sra_pkg::VALUE_W-1:0] val;
      int                          wait_cycles;

      mismatch_count   = 0;
      quiet_stretch    = 1'b0;
      shadow_store     = '{default: '0};
      shadow_root      = 0;
      shadow_depth     = 0;
      shadow_next_free = 1;
      shadow_count     = 0;
      shadow_top       = -1;
      shadow_gaps      = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.cmd     = '0;
      req_chan.index   = '0;
      req_chan.value   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (access_table[i])
         send_access(access_table[i].cmd, access_table[i].idx, access_table[i].val,
                     access_table[i].status);

      // Random part. Early on most accesses stay inside a few small regions so
      // that gets and removes hit stored values; later, wide indices drain the
      // pool and exercise the exhaustion path.
      for (int n = 0; n < 800; n++) begin
         quiet_stretch = (n >= 300 && n < 420);
         cmd = $urandom_range(99) < 40 ? sra_pkg::CMD_SET :
               ($urandom_range(1) ? sra_pkg::CMD_GET : sra_pkg::CMD_REMOVE);
         if ($urandom_range(99) < 3) cmd = CMD_UNUSED;
         region = {4'($urandom_range(3)), 16'h0} | {4'h0, 4'($urandom_range(1)), 12'h0};
         if (n > 600 || $urandom_range(99) < 15) idx = 20'($urandom);
         else idx = region | 20'($urandom_range(63));
         val = $urandom_range(99) < 3 ? 32'h0 : $urandom;
         send_access(cmd, idx, val, -1);
      end
      req_chan.valid <= 1'b0;
      quiet_stretch = 1'b0;

      wait_cycles = 0;
      while (pending_replies.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("sparse_radix_array_engine_unit verification clean");
      end else begin
         $display("sparse_radix_array_engine_unit verification failed");
      end
      $finish;
   end

endmodule
